// ===== src/qtu_pkg.sv =====
// Shared types, constants and codes of the Q-table update block.
package qtu_pkg;

  // Default sizes of the table
  localparam int STATE_BITS_DEF = 12;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed field widths
  localparam int ACTIONS          = 4;
  localparam int ACT_BITS         = 2;
  localparam int FIELD_STATE_BITS = 12;
  localparam int REWARD_BITS      = 32;
  localparam int OUT_VALUE_BITS   = 32;
  localparam int FRAC_BITS        = 16;
  localparam int CFG_INDEX_BITS   = 2;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEARNING_RATE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DISCOUNT      = 2'd1;

  // Register reset values
  localparam logic [FRAC_BITS-1:0] LEARNING_RATE_RESET = 16'd19661;
  localparam logic [FRAC_BITS-1:0] DISCOUNT_RESET      = 16'd52429;

  typedef struct packed {
    logic [FIELD_STATE_BITS-1:0]   state_index;
    logic [ACT_BITS-1:0]           action_taken;
    logic signed [REWARD_BITS-1:0] reward;
    logic [FIELD_STATE_BITS-1:0]   next_state;
  } in_t;

  typedef struct packed {
    logic signed [OUT_VALUE_BITS-1:0] new_value;
    logic signed [OUT_VALUE_BITS-1:0] next_max_value;
    logic [ACT_BITS-1:0]              next_best_action;
    logic                             saturated;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic                clr_wr;
    logic                take_in;
    logic                rd_en;
    logic                rd_cur;
    logic [ACT_BITS-1:0] rd_act;
    logic                cmp_en;
    logic                cmp_first;
    logic [ACT_BITS-1:0] cmp_act;
    logic                cap_cur;
    logic                calc_td;
    logic                calc_step;
    logic                write_back;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
  } stat_t;

endpackage

// ===== src/qtu_mem.sv =====
// Single write port, single registered read port table memory.
module qtu_mem #(
  parameter int ADDR_BITS = 14,
  parameter int DATA_BITS = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/qtu_ctrl.sv =====
// Sequencer of the Q-table update: clear sweep, row reads, arithmetic steps, write-back.
module qtu_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output qtu_pkg::cmd_t cmd,
  input  qtu_pkg::stat_t stat
);
  import qtu_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ROW   = 3'd2;
  localparam logic [2:0] S_CUR   = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_DIFF  = 3'd5;
  localparam logic [2:0] S_SCALE = 3'd6;
  localparam logic [2:0] S_WRITE = 3'd7;

  logic [2:0]          state, state_next;
  logic [ACT_BITS-1:0] cnt, cnt_next;
  logic                pend, pend_next;
  logic [ACT_BITS-1:0] pend_act, pend_act_next;
  logic                out_valid_next;
  logic                out_free;

  assign out_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    pend_next      = 1'b0;
    pend_act_next  = cnt;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.cmp_en     = pend;
    cmd.cmp_act    = pend_act;
    cmd.cmp_first  = (pend_act == '0);
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          cnt_next    = '0;
          state_next  = S_ROW;
        end
      end
      S_ROW: begin
        // Issue one read of the next state's row per cycle
        cmd.rd_en     = 1'b1;
        cmd.rd_act    = cnt;
        pend_next     = 1'b1;
        pend_act_next = cnt;
        cnt_next      = cnt + 1'b1;
        if (cnt == ACT_BITS'(ACTIONS - 1)) begin
          state_next = S_CUR;
        end
      end
      S_CUR: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_cur = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.cap_cur = 1'b1;
        state_next  = S_DIFF;
      end
      S_DIFF: begin
        cmd.calc_td = 1'b1;
        state_next  = S_SCALE;
      end
      S_SCALE: begin
        cmd.calc_step = 1'b1;
        state_next    = S_WRITE;
      end
      S_WRITE: begin
        // Hold until the output register is free
        if (out_free) begin
          cmd.write_back = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      pend      <= 1'b0;
      pend_act  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      pend      <= pend_next;
      pend_act  <= pend_act_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== src/qtu_dp.sv =====
// Datapath of the Q-table update: operand registers, max search, two fraction multiplies.
module qtu_dp #(
  parameter int STATE_BITS = qtu_pkg::STATE_BITS_DEF,
  parameter int VALUE_BITS = qtu_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  qtu_pkg::cmd_t                        cmd,
  output qtu_pkg::stat_t                       stat,
  input  qtu_pkg::in_t                         in_data,
  output qtu_pkg::out_t                        out_data,
  input  logic                                 cfg_valid,
  input  logic [qtu_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [qtu_pkg::FRAC_BITS-1:0]        cfg_data,
  output logic                                 mem_we,
  output logic [STATE_BITS+qtu_pkg::ACT_BITS-1:0] mem_waddr,
  output logic [VALUE_BITS-1:0]                mem_wdata,
  output logic                                 mem_re,
  output logic [STATE_BITS+qtu_pkg::ACT_BITS-1:0] mem_raddr,
  input  logic [VALUE_BITS-1:0]                mem_rdata
);
  import qtu_pkg::*;

  localparam int AW  = STATE_BITS + ACT_BITS;
  localparam int SXW = (STATE_BITS > FIELD_STATE_BITS) ? STATE_BITS : FIELD_STATE_BITS;
  localparam int SW  = ((VALUE_BITS > REWARD_BITS) ? VALUE_BITS : REWARD_BITS) + 2;
  localparam int NW  = SW + 1;
  localparam int OW  = (VALUE_BITS > OUT_VALUE_BITS) ? VALUE_BITS : OUT_VALUE_BITS;
  localparam logic signed [NW-1:0] VMAX = NW'({1'b0, {(VALUE_BITS-1){1'b1}}});
  localparam logic signed [NW-1:0] VMIN = ~VMAX;

  // Configuration
  logic [FRAC_BITS-1:0] lr, disc;

  // Captured item
  logic [STATE_BITS-1:0]         s, sn;
  logic [ACT_BITS-1:0]           a;
  logic signed [REWARD_BITS-1:0] r;

  // Working values
  logic signed [VALUE_BITS-1:0] best, cur, gm;
  logic [ACT_BITS-1:0]          best_a;
  logic signed [SW-1:0]         td, step;
  logic [AW-1:0]                clr_cnt;

  logic [SXW-1:0]                 s_ext, sn_ext;
  logic signed [VALUE_BITS-1:0]   rd_val;
  logic signed [VALUE_BITS+16:0]  prod_g;
  logic signed [SW+16:0]          prod_a;
  logic signed [NW-1:0]           sum;
  logic signed [VALUE_BITS-1:0]   nv;
  logic                           sat;
  logic signed [OW-1:0]           nv_ext, best_ext;

  assign s_ext  = SXW'(in_data.state_index);
  assign sn_ext = SXW'(in_data.next_state);
  assign rd_val = $signed(mem_rdata);

  // Fraction products, floor of the scaled result
  assign prod_g = $signed({1'b0, disc}) * best;
  assign prod_a = $signed({1'b0, lr}) * td;

  // New value with clamp to the value range
  assign sum = NW'(cur) + NW'(step);
  always_comb begin
    sat = 1'b0;
    nv  = sum[VALUE_BITS-1:0];
    if (sum > VMAX) begin
      nv  = VMAX[VALUE_BITS-1:0];
      sat = 1'b1;
    end else if (sum < VMIN) begin
      nv  = VMIN[VALUE_BITS-1:0];
      sat = 1'b1;
    end
  end

  assign nv_ext   = OW'(nv);
  assign best_ext = OW'(best);

  // Memory ports
  assign mem_re    = cmd.rd_en;
  assign mem_raddr = cmd.rd_cur ? {s, a} : {sn, cmd.rd_act};
  assign mem_we    = cmd.clr_wr || cmd.write_back;
  assign mem_waddr = cmd.clr_wr ? clr_cnt : {s, a};
  assign mem_wdata = cmd.clr_wr ? '0 : nv;

  assign stat.clr_last = &clr_cnt;

  // Configuration registers and clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      lr      <= LEARNING_RATE_RESET;
      disc    <= DISCOUNT_RESET;
      clr_cnt <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_LEARNING_RATE: lr   <= cfg_data;
          REG_DISCOUNT:      disc <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clr_wr) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Operand and result registers
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      s  <= s_ext[STATE_BITS-1:0];
      sn <= sn_ext[STATE_BITS-1:0];
      a  <= in_data.action_taken;
      r  <= in_data.reward;
    end
    // Running maximum, lowest action wins ties
    if (cmd.cmp_en && (cmd.cmp_first || rd_val > best)) begin
      best   <= rd_val;
      best_a <= cmd.cmp_act;
    end
    if (cmd.cap_cur) begin
      cur <= rd_val;
      gm  <= prod_g[VALUE_BITS+15:16];
    end
    if (cmd.calc_td) begin
      td <= SW'(r) + SW'(gm) - SW'(cur);
    end
    if (cmd.calc_step) begin
      step <= prod_a[SW+15:16];
    end
    if (cmd.write_back) begin
      out_data.new_value        <= nv_ext[OUT_VALUE_BITS-1:0];
      out_data.next_max_value   <= best_ext[OUT_VALUE_BITS-1:0];
      out_data.next_best_action <= best_a;
      out_data.saturated        <= sat;
    end
  end

endmodule

// ===== src/q_table_update.sv =====
// Top level of the tabular Q-learning update block.
//
//   channel  dir  handshake             beat
//   in       in   in_valid / in_ready   in_data  (state, action, reward, next state)
//   out      out  out_valid / out_ready out_data (new value, next max, best action, flag)
//   cfg      in   cfg_valid / cfg_ready cfg_index, cfg_data (ready whenever rst is low)
//
// After reset the table is swept to zero, one entry per cycle, all 2^(STATE_BITS+2)
// entries, with in_ready low; configuration beats are taken during the sweep.
// Each item passes through five reads on the single table read port, the gamma and
// alpha multiplies, and the write-back before the next in_ready.
// The write-back stalls while an earlier result beat is still held on out.
module q_table_update #(
  parameter int STATE_BITS = qtu_pkg::STATE_BITS_DEF,
  parameter int VALUE_BITS = qtu_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  qtu_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output qtu_pkg::out_t                      out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [qtu_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [qtu_pkg::FRAC_BITS-1:0]      cfg_data
);
  import qtu_pkg::*;

  localparam int AW = STATE_BITS + ACT_BITS;

  cmd_t                  cmd;
  stat_t                 stat;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [VALUE_BITS-1:0] mem_wdata, mem_rdata;

  // Refuse register beats while reset holds the registers
  assign cfg_ready = !rst;

  qtu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  qtu_dp #(
    .STATE_BITS (STATE_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  qtu_mem #(
    .ADDR_BITS (AW),
    .DATA_BITS (VALUE_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
